/* src/abs_pkg.sv */
// ----------------------------------------------------------------------------
// abs_pkg
// Shared sizes, request and status codes, and beat types of the bag/stack.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_POP      = 2'd3
  } req_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] top_value;
    logic [7:0]         entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  // Per-cell move: push takes the upper neighbor, pull takes the lower one.
  typedef struct packed {
    logic push;
    logic pull;
  } cell_ctl_t;

endpackage

/* src/array_bag_stack_unit.sv */
// ----------------------------------------------------------------------------
// array_bag_stack_unit
// Fixed-capacity bag and stack: push, contains, remove-first and pop.
// ----------------------------------------------------------------------------
// Entries sit in a chain of cells with the newest entry in cell 0, so the top
// is always read from cell 0. Every cell compares its entry with the request
// value at once; a suffix OR picks the oldest match, and every cell from that
// one down to the last cell pulls its lower neighbor to close the gap. Push
// moves all cells one step deeper and loads the value into cell 0; pop pulls
// all cells one step. Each request is handled by a single compare, scan and
// shift across the cell row, and its result beat is held in an output
// register, so a new request is taken every cycle while the result side keeps
// up. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module array_bag_stack_unit
  import abs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   acc;
  logic [31:0]            raw_value;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] val      [CAPACITY];
  logic [VALUE_WIDTH-1:0] down_in  [CAPACITY];
  logic [VALUE_WIDTH-1:0] up_in    [CAPACITY];
  logic [CAPACITY-1:0]    occupied;
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    deeper;
  logic                   any_match;
  cell_ctl_t              ctl [CAPACITY];
  logic                   push;
  logic                   pull_all;
  logic                   pull_rem;
  logic                   hit;
  status_t                status;
  logic [VALUE_WIDTH-1:0] top_next;
  rsp_t                   rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign acc       = req_valid && req_ready;
  assign raw_value = req.item_value;
  assign key       = VALUE_WIDTH'(raw_value);

  // Cell row
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    assign occupied[k] = CNT_W'(k) < count;
    assign up_in[k]    = (k == 0) ? key : val[(k == 0) ? 0 : k - 1];
    assign down_in[k]  = (k == CAPACITY - 1) ? val[k]
                                             : val[(k == CAPACITY - 1) ? k : k + 1];
    assign ctl[k].push = push;
    assign ctl[k].pull = pull_all || (pull_rem && !deeper[k]);

    abs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[k]),
      .key       (key),
      .occupied  (occupied[k]),
      .from_up   (up_in[k]),
      .from_down (down_in[k]),
      .value     (val[k]),
      .match     (match[k])
    );
  end

  abs_scan u_scan (
    .match     (match),
    .deeper    (deeper),
    .any_match (any_match)
  );

  always_comb begin
    push       = 1'b0;
    pull_all   = 1'b0;
    pull_rem   = 1'b0;
    hit        = 1'b0;
    status     = ST_OK;
    count_next = count;
    case (req.req_type)
      OP_ADD: begin
        if (count == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          push       = acc;
          count_next = count + CNT_W'(1);
        end
      end
      OP_CONTAINS: begin
        hit = any_match;
      end
      OP_REMOVE: begin
        if (any_match) begin
          hit        = 1'b1;
          pull_rem   = acc;
          count_next = count - CNT_W'(1);
        end else begin
          status = ST_MISSING;
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          pull_all   = acc;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    // Cell 0 after this beat
    if (push) begin
      top_next = key;
    end else if (ctl[0].pull) begin
      top_next = down_in[0];
    end else begin
      top_next = val[0];
    end

    rsp_next.hit         = hit;
    rsp_next.top_value   = (count_next == '0) ? '0 : 32'(top_next);
    rsp_next.entry_count = 8'(count_next);
    rsp_next.is_empty    = (count_next == '0);
    rsp_next.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> count == CNT_W'(CAPACITY))
    else $error("full status reported while not full");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.status == ST_OK)
    else $error("hit reported with error status");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    acc && req.req_type == OP_ADD && count != CNT_W'(CAPACITY)
    |=> count == $past(count) + CNT_W'(1))
    else $error("push did not advance the entry count");

endmodule

/* src/abs_cell.sv */
// ----------------------------------------------------------------------------
// abs_cell
// One storage cell of the chain: holds an entry, compares it with the key
// and takes a neighbor's entry on push or pull.
// ----------------------------------------------------------------------------
module abs_cell
  import abs_pkg::*;
(
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic                   occupied,
  input  logic [VALUE_WIDTH-1:0] from_up,
  input  logic [VALUE_WIDTH-1:0] from_down,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   match
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      value <= from_up;
    end else if (ctl.pull) begin
      value <= from_down;
    end
  end

  assign match = occupied && (value == key);

endmodule

/* src/abs_scan.sv */
// ----------------------------------------------------------------------------
// abs_scan
// Log-depth suffix OR over the cell match flags: marks every cell that has
// a matching cell deeper in the chain.
// ----------------------------------------------------------------------------
module abs_scan
  import abs_pkg::*;
(
  input  logic [CAPACITY-1:0] match,
  output logic [CAPACITY-1:0] deeper,
  output logic                any_match
);

  localparam int LVL = $clog2(CAPACITY);

  logic [CAPACITY-1:0] lvl [0:LVL];

  always_comb begin
    lvl[0] = match;
    for (int l = 0; l < LVL; l++) begin
      lvl[l+1] = lvl[l] | (lvl[l] >> (1 << l));
    end
  end

  // Bit k of the last level covers cells k and up; shift to exclude cell k.
  assign deeper    = lvl[LVL] >> 1;
  assign any_match = lvl[LVL][0];

endmodule

/* bench/array_bag_stack_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_bag_stack_unit_tb
// Self-checking bench for the bag/stack unit. A local copy of the entry array
// predicts every response beat. Directed tests cover the value extremes, the
// empty, full and missing cases and duplicates. A long output stall backs up
// requests, then biased random traffic follows. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module array_bag_stack_unit_tb;
  import abs_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 8;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Predicted contents: slot stack_fill-1 is the top.
  logic [31:0] stack_mem [CAPACITY];
  int          stack_fill;
  rsp_t        expected_rsp_q [$];

  int mismatch_count;
  int burst_left;
  bit gap_enable;
  int hold_grant;
  int idle_cycles;

  array_bag_stack_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int find_slot(logic [31:0] v);
    for (int i = 0; i < stack_fill; i++) begin
      if (stack_mem[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t bag_stack_step(req_t r);
    rsp_t        o;
    int          pos;
    logic [31:0] v;
    o = '0;
    v = r.item_value;
    case (req_op_t'(r.req_type))
      OP_ADD: begin
        if (stack_fill >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = v;
          stack_fill++;
        end
      end
      OP_CONTAINS: begin
        o.hit = (find_slot(v) >= 0);
      end
      OP_REMOVE: begin
        pos = find_slot(v);
        if (pos < 0) begin
          o.status = ST_MISSING;
        end else begin
          // close the gap left by the lowest-index copy
          for (int j = pos; j + 1 < stack_fill; j++) stack_mem[j] = stack_mem[j + 1];
          stack_fill--;
          o.hit = 1'b1;
        end
      end
      default: begin
        if (stack_fill == 0) o.status = ST_EMPTY;
        else stack_fill--;
      end
    endcase
    if (stack_fill > 0) o.top_value = stack_mem[stack_fill - 1];
    o.entry_count = 8'(stack_fill);
    o.is_empty    = (stack_fill == 0);
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Send one request beat; entered and left at a falling edge.
  task automatic send_req(req_op_t op, logic [31:0] value);
    req_t item;
    item.req_type   = op;
    item.item_value = value;
    req       = item;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp_q.push_back(bag_stack_step(item));
    @(negedge clk);
    if (gap_enable) begin
      if (burst_left == 0) begin
        req_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Response checker.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: response beat with nothing expected", $realtime);
        mismatch_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.hit !== want.hit)
          report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
        if (rsp.top_value !== want.top_value)
          report_mismatch("top_value", rsp.top_value, want.top_value);
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
        if (rsp.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("array_bag_stack_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall patterns, plus a long hold on request.
  initial begin
    int seen;
    int hold_left;
    int phase_left;
    int mode;
    int tick;
    seen       = 0;
    hold_left  = 0;
    phase_left = 0;
    mode       = 0;
    tick       = 0;
    rsp_ready  = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_grant != seen) begin
        seen      = hold_grant;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready = 1'b0;
      end else begin
        case (mode)
          0:       rsp_ready = 1'b1;
          1:       rsp_ready = ($urandom_range(0, 99) >= 25);
          2:       rsp_ready = ($urandom_range(0, 99) >= 60);
          default: rsp_ready = (tick % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && stack_fill > 0) return stack_mem[$urandom_range(0, stack_fill - 1)];
    if (sel < 5) return $urandom_range(0, 15);
    if (sel == 5) return -$urandom_range(1, 8);
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  task automatic test_empty_unit();
    send_req(OP_CONTAINS, 32'h0000_0000);
    send_req(OP_POP, 32'hFFFF_FFFF);
    send_req(OP_REMOVE, 32'h0000_0001);
  endtask

  task automatic test_value_extremes();
    logic [31:0] vals [6];
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
             32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (vals[i]) send_req(OP_ADD, vals[i]);
    foreach (vals[i]) send_req(OP_CONTAINS, vals[i]);
    send_req(OP_CONTAINS, 32'h1234_5678);
    send_req(OP_REMOVE, 32'h0000_0000);
    send_req(OP_REMOVE, 32'h0000_0000);
    send_req(OP_POP, 32'h0);
  endtask

  task automatic test_duplicates();
    // remove must take the oldest copy only
    send_req(OP_ADD, 32'd5);
    send_req(OP_ADD, 32'd7);
    send_req(OP_ADD, 32'd5);
    send_req(OP_REMOVE, 32'd5);
    send_req(OP_CONTAINS, 32'd5);
    send_req(OP_REMOVE, 32'd5);
    send_req(OP_CONTAINS, 32'd5);
  endtask

  task automatic test_fill_and_drain();
    int n;
    n = CAPACITY - stack_fill + 2;
    repeat (n) send_req(OP_ADD, $urandom());
    send_req(OP_CONTAINS, stack_mem[0]);
    n = stack_fill + 1;
    repeat (n) send_req(OP_POP, $urandom());
  endtask

  task automatic test_output_backpressure();
    bit saved_gap;
    saved_gap  = gap_enable;
    gap_enable = 1'b0;
    hold_grant++;
    repeat (40) send_req(req_op_t'($urandom_range(0, 3)), pick_value());
    gap_enable = saved_gap;
  endtask

  task automatic test_random_traffic(int n);
    int bias;
    int w;
    req_op_t op;
    bias = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0) begin
        bias       = $urandom_range(0, 3);
        gap_enable = ($urandom_range(0, 3) != 0);
      end
      w = $urandom_range(0, 99);
      case (bias)
        0:       op = (w < 55) ? OP_ADD : (w < 70) ? OP_CONTAINS : (w < 85) ? OP_REMOVE : OP_POP;
        1:       op = (w < 20) ? OP_ADD : (w < 40) ? OP_CONTAINS : (w < 70) ? OP_REMOVE : OP_POP;
        2:       op = req_op_t'(w % 4);
        default: op = (w < 85) ? OP_ADD : (w < 92) ? OP_CONTAINS : OP_REMOVE;
      endcase
      send_req(op, pick_value());
    end
  endtask

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    stack_fill     = 0;
    mismatch_count = 0;
    burst_left     = 0;
    gap_enable     = 1'b1;
    hold_grant     = 0;
    idle_cycles    = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_empty_unit();
    test_value_extremes();
    test_duplicates();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_traffic(1480);

    req_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("array_bag_stack_unit regression: pass");
    end else begin
      $display("array_bag_stack_unit regression: fail");
    end
    $finish;
  end

endmodule

/* array_bag_stack_unit.f */
src/abs_pkg.sv
src/abs_cell.sv
src/abs_scan.sv
src/array_bag_stack_unit.sv
bench/array_bag_stack_unit_tb.sv
